@@ src/sii_pkg.sv @@
// Package for the sorted integer index unit: sizes, request codes and sequencer states.
// It depends on nothing else.
// It is used by sorted_integer_index_unit.
`default_nettype none

package sii_pkg;

	// Number of entries the index holds.
	localparam int INDEX_DEPTH = 256;
	localparam int ADDR_W      = $clog2(INDEX_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 32;
	localparam int ROW_W       = 15;
	localparam int POS_W       = 10;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_EXACT  = 2'd1,
		REQ_FIRST  = 2'd2,
		REQ_LAST   = 2'd3
	} req_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BS_CHK,
		ST_BS_CMP,
		ST_END,
		ST_SH_PRIME,
		ST_SH_MOVE,
		ST_INS,
		ST_ROW,
		ST_RESP
	} state_t;

	// One stored entry.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ROW_W-1:0] row;
	} entry_t;

endpackage

`default_nettype wire

@@ src/sorted_integer_index_unit.sv @@
// Sorted integer index: sorted key and row id pairs with binary search and insert.
// It depends on sii_pkg for sizes, request codes, states and the entry type.
// Flow: a search runs at most nine probes, each a check then a compare, then a closing check,
// the position step, a row read and the load, which waits for a free output register. An
// insert shifts entries up one at a time (up to 255), then writes. No item is taken before
// the cycle after the load; reset clears count and sequencer, not memory.
`default_nettype none

module sorted_integer_index_unit
	import sii_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // key [31:0], row_id [46:32], zero [47]
	input  wire logic [1:0]  s_tuser,   // req_type [1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // position [9:0], row_at_position [24:10], zero [31:25]
	output logic [1:0]       m_tuser    // hit [0], full_error [1]
);

	state_t state_q, state_d;

	// Request registers.
	req_t              req_q;
	logic [KEY_W-1:0]  key_q;
	logic [ROW_W-1:0]  rid_q;

	// Search bounds: lo_q and one past the upper bound.
	logic [CNT_W-1:0]  lo_q, hix_q, count_q, wr_idx_q;
	logic [ADDR_W-1:0] mid_q;
	logic              found_q;

	// Result being built.
	logic [POS_W-1:0]  res_pos_q;
	logic [ROW_W-1:0]  res_row_q;
	logic              res_hit_q, res_full_q;

	// Output register.
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	// Memory.
	entry_t            mem [INDEX_DEPTH];
	entry_t            rdata_q;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	entry_t            wr_data;

	logic              accept, out_free;
	logic [CNT_W:0]    mid_sum;
	logic [ADDR_W-1:0] mid;
	logic              probe_go;
	logic              key_lt, key_eq;
	logic [POS_W-1:0]  pos_calc;
	logic              pos_valid;
	logic [CNT_W-1:0]  wr_dec, wr_dec2;
	logic              full, empty;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (count_q == CNT_W'(INDEX_DEPTH));
	assign empty    = (count_q == '0);

	// Midpoint of the live range.
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hix_q} - (CNT_W+1)'(1);
	assign mid      = mid_sum[ADDR_W:1];
	assign probe_go = (lo_q < hix_q);

	// Shared compare unit: stored key against the request key, both signed.
	assign key_lt = $signed(rdata_q.key) < $signed(key_q);
	assign key_eq = (rdata_q.key == key_q);

	assign wr_dec  = wr_idx_q - CNT_W'(1);
	assign wr_dec2 = wr_idx_q - CNT_W'(2);

	// Position reported once the search has settled.
	always_comb begin
		case (req_q)
			REQ_INSERT, REQ_FIRST: pos_calc = POS_W'(lo_q);
			REQ_LAST:              pos_calc = POS_W'(lo_q) - POS_W'(1);
			REQ_EXACT:             pos_calc = found_q ? POS_W'(mid_q) : '1;
			default:               pos_calc = '1;
		endcase
	end
	assign pos_valid = !pos_calc[POS_W-1] && (pos_calc[CNT_W-1:0] < count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == REQ_INSERT) begin
						state_d = full ? ST_RESP : ST_BS_CHK;
					end else begin
						state_d = empty ? ST_RESP : ST_BS_CHK;
					end
				end
			end
			ST_BS_CHK: begin
				state_d = probe_go ? ST_BS_CMP : ST_END;
			end
			ST_BS_CMP: begin
				state_d = (req_q == REQ_EXACT && key_eq) ? ST_END : ST_BS_CHK;
			end
			ST_END: begin
				if (req_q == REQ_INSERT) begin
					state_d = (count_q > lo_q) ? ST_SH_PRIME : ST_INS;
				end else begin
					state_d = pos_valid ? ST_ROW : ST_RESP;
				end
			end
			ST_SH_PRIME: state_d = ST_SH_MOVE;
			ST_SH_MOVE: begin
				state_d = (wr_dec > lo_q) ? ST_SH_MOVE : ST_INS;
			end
			ST_INS:  state_d = ST_RESP;
			ST_ROW:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls for each state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid;
		wr_en   = 1'b0;
		wr_addr = wr_idx_q[ADDR_W-1:0];
		wr_data = rdata_q;
		case (state_q)
			ST_BS_CHK: begin
				rd_en   = probe_go;
				rd_addr = mid;
			end
			ST_END: begin
				rd_en   = (req_q != REQ_INSERT) && pos_valid;
				rd_addr = pos_calc[ADDR_W-1:0];
			end
			ST_SH_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = wr_dec[ADDR_W-1:0];
			end
			ST_SH_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = wr_idx_q[ADDR_W-1:0];
				wr_data = rdata_q;
				rd_en   = (wr_dec > lo_q);
				rd_addr = wr_dec2[ADDR_W-1:0];
			end
			ST_INS: begin
				wr_en        = 1'b1;
				wr_addr      = lo_q[ADDR_W-1:0];
				wr_data.key  = key_q;
				wr_data.row  = rid_q;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	// Entry memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INS) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q      <= req_t'(s_tuser);
					key_q      <= s_tdata[KEY_W-1:0];
					rid_q      <= s_tdata[KEY_W+ROW_W-1:KEY_W];
					lo_q       <= '0;
					hix_q      <= count_q;
					found_q    <= 1'b0;
					res_pos_q  <= '1;
					res_row_q  <= '0;
					res_hit_q  <= 1'b0;
					res_full_q <= (s_tuser == REQ_INSERT) && full;
				end
			end
			ST_BS_CHK: begin
				if (probe_go) begin
					mid_q <= mid;
				end
			end
			ST_BS_CMP: begin
				// Narrow the range by the kind of search.
				case (req_q)
					REQ_EXACT: begin
						if (key_eq) begin
							found_q <= 1'b1;
						end else if (key_lt) begin
							lo_q <= CNT_W'(mid_q) + CNT_W'(1);
						end else begin
							hix_q <= CNT_W'(mid_q);
						end
					end
					REQ_FIRST: begin
						if (key_lt) begin
							lo_q <= CNT_W'(mid_q) + CNT_W'(1);
						end else begin
							hix_q <= CNT_W'(mid_q);
						end
					end
					default: begin
						if (key_lt || key_eq) begin
							lo_q <= CNT_W'(mid_q) + CNT_W'(1);
						end else begin
							hix_q <= CNT_W'(mid_q);
						end
					end
				endcase
			end
			ST_END: begin
				res_pos_q  <= pos_calc;
				res_full_q <= 1'b0;
				wr_idx_q   <= count_q;
				if (req_q == REQ_INSERT) begin
					res_hit_q <= 1'b1;
					res_row_q <= rid_q;
				end else begin
					res_hit_q <= pos_valid;
					res_row_q <= '0;
				end
			end
			ST_SH_MOVE: begin
				wr_idx_q <= wr_dec;
			end
			ST_ROW: begin
				res_row_q <= rdata_q.row;
			end
			ST_RESP: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, res_row_q, res_pos_q};
					m_tuser_q <= {res_full_q, res_hit_q};
				end
			end
			default: begin
				mid_q <= mid_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The entry count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(INDEX_DEPTH))
		else $error("entry count beyond depth");

	// A hit never reports a negative position.
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && res_hit_q) |-> !res_pos_q[POS_W-1])
		else $error("hit with negative position");

	// Every completed insert adds exactly one entry.
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not add one entry");

endmodule

`default_nettype wire
